FILE: sv/md5_pkg.sv
package md5_pkg;

   // Chaining words after reset
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // Sine-derived round constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [3:0] LEN_LO_POS  = 4'd14;
   localparam logic [3:0] LAST_POS    = 4'd15;
   localparam logic [2:0] FULL_BYTES  = 3'd4;
   localparam logic [1:0] LAST_DIGEST = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_ADD,
      ST_DONE
   } state_type;

   // Source of the word written into the block buffer
   typedef enum logic [2:0] {
      SRC_DATA,
      SRC_PAD80,
      SRC_ZERO,
      SRC_LEN_LO,
      SRC_LEN_HI
   } push_src_type;

   typedef struct packed {
      logic         push;
      push_src_type src;
      logic         round_en;
      logic [5:0]   round;
      logic         chain_add;
      logic         finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] pos;
      logic       emit_busy;
   } dp_status_type;

   // Rotate amount for a round
   function automatic logic [4:0] rot_amount(logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'h0: s = 5'd7;
         4'h1: s = 5'd12;
         4'h2: s = 5'd17;
         4'h3: s = 5'd22;
         4'h4: s = 5'd5;
         4'h5: s = 5'd9;
         4'h6: s = 5'd14;
         4'h7: s = 5'd20;
         4'h8: s = 5'd4;
         4'h9: s = 5'd11;
         4'hA: s = 5'd16;
         4'hB: s = 5'd23;
         4'hC: s = 5'd6;
         4'hD: s = 5'd10;
         4'hE: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   // Message word taken by a round
   function automatic logic [3:0] msg_index(logic [5:0] r);
      logic [3:0] r4;
      logic [3:0] idx;
      r4 = r[3:0];
      case (r[5:4])
         2'd0: idx = r4;
         2'd1: idx = r4 * 4'd5 + 4'd1;
         2'd2: idx = r4 * 4'd3 + 4'd5;
         default: idx = r4 * 4'd7;
      endcase
      return idx;
   endfunction

   function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

endpackage

FILE: sv/md5_if.sv
// Message word channel
interface md5_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic        last_word;

   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

// Digest word channel
interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_number;
   logic        last_of_digest;

   modport source (output valid, digest_word, word_number, last_of_digest, input ready);
   modport sink (input valid, digest_word, word_number, last_of_digest, output ready);
endinterface

FILE: sv/md5_ctrl.sv
module md5_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_word,
   input  logic [2:0]             req_byte_count,
   output logic                   req_ready,
   input  md5_pkg::dp_status_type status,
   output md5_pkg::dp_cmd_type    cmd
);

   md5_pkg::state_type state_ff, state_in;
   logic [5:0] round_ff, round_in;
   logic       pad_ff, pad_in;       // padding of the final block under way
   logic       extra_ff, extra_in;   // separate 0x80 word still owed
   logic       len_ff, len_in;       // low length word written
   logic       final_ff, final_in;   // high length word written

   // State and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::ST_IDLE;
         round_ff <= '0;
         pad_ff   <= 1'b0;
         extra_ff <= 1'b0;
         len_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pad_ff   <= pad_in;
         extra_ff <= extra_in;
         len_ff   <= len_in;
         final_ff <= final_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      pad_in        = pad_ff;
      extra_in      = extra_ff;
      len_in        = len_ff;
      final_in      = final_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.src       = md5_pkg::SRC_ZERO;
      cmd.round     = round_ff;
      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               cmd.src  = md5_pkg::SRC_DATA;
               if (req_last_word) begin
                  pad_in   = 1'b1;
                  extra_in = (req_byte_count >= md5_pkg::FULL_BYTES);
               end
               if (status.pos == md5_pkg::LAST_POS) begin
                  state_in = md5_pkg::ST_COMPRESS;
               end else if (req_last_word) begin
                  state_in = md5_pkg::ST_PAD;
               end
            end
         end
         md5_pkg::ST_PAD: begin
            cmd.push = 1'b1;
            if (extra_ff) begin
               cmd.src  = md5_pkg::SRC_PAD80;
               extra_in = 1'b0;
            end else if (len_ff) begin
               cmd.src  = md5_pkg::SRC_LEN_HI;
               final_in = 1'b1;
            end else if (status.pos == md5_pkg::LEN_LO_POS) begin
               cmd.src = md5_pkg::SRC_LEN_LO;
               len_in  = 1'b1;
            end else begin
               cmd.src = md5_pkg::SRC_ZERO;
            end
            if (status.pos == md5_pkg::LAST_POS) begin
               state_in = md5_pkg::ST_COMPRESS;
            end
         end
         md5_pkg::ST_COMPRESS: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 6'd1;
            if (round_ff == md5_pkg::LAST_ROUND) begin
               state_in = md5_pkg::ST_ADD;
            end
         end
         md5_pkg::ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (final_ff) begin
               state_in = md5_pkg::ST_DONE;
            end else if (pad_ff) begin
               state_in = md5_pkg::ST_PAD;
            end else begin
               state_in = md5_pkg::ST_IDLE;
            end
         end
         md5_pkg::ST_DONE: begin
            // Wait for the previous digest to drain
            if (!status.emit_busy) begin
               cmd.finish = 1'b1;
               pad_in     = 1'b0;
               extra_in   = 1'b0;
               len_in     = 1'b0;
               final_in   = 1'b0;
               state_in   = md5_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   a_no_push_in_rounds: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> !cmd.push && !cmd.chain_add)
      else $error("buffer written during compression");

   a_wrap_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && status.pos == md5_pkg::LAST_POS) |=> state_ff == md5_pkg::ST_COMPRESS)
      else $error("full block not compressed");

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.emit_busy)
      else $error("digest overwritten before delivery");

   a_length_after_pad: assert property (@(posedge clock) disable iff (reset)
      len_ff |-> !extra_ff && pad_ff)
      else $error("length written before padding byte");

endmodule

FILE: sv/md5_dp.sv
module md5_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  md5_pkg::dp_cmd_type    cmd,
   output md5_pkg::dp_status_type status,
   input  logic [31:0]            req_data_word,
   input  logic [2:0]             req_byte_count,
   input  logic                   req_last_word,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_digest_word,
   output logic [1:0]             rsp_word_number,
   output logic                   rsp_last_of_digest
);

   logic [31:0] blk_ff [16];
   logic [31:0] chain_ff [4];
   logic [31:0] out_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] b_in;
   logic [3:0]  pos_ff;
   logic [63:0] bits_ff;
   logic        busy_ff;
   logic [1:0]  idx_ff;
   logic [2:0]  count;
   logic [31:0] data_padded;
   logic [31:0] push_word;
   logic [5:0]  bit_add;
   logic [31:0] f;
   logic [31:0] sum;

   // Clamp the byte count and pad the last data word
   always_comb begin
      count = (req_byte_count > md5_pkg::FULL_BYTES) ? md5_pkg::FULL_BYTES : req_byte_count;
      case (count)
         3'd0: data_padded = 32'h0000_0080;
         3'd1: data_padded = {16'h0000, 8'h80, req_data_word[7:0]};
         3'd2: data_padded = {8'h00, 8'h80, req_data_word[15:0]};
         3'd3: data_padded = {8'h80, req_data_word[23:0]};
         default: data_padded = req_data_word;
      endcase
      bit_add = req_last_word ? {count, 3'b000} : 6'd32;
   end

   // Select the word written into the buffer
   always_comb begin
      case (cmd.src)
         md5_pkg::SRC_DATA:   push_word = req_last_word ? data_padded : req_data_word;
         md5_pkg::SRC_PAD80:  push_word = 32'h0000_0080;
         md5_pkg::SRC_LEN_LO: push_word = bits_ff[31:0];
         md5_pkg::SRC_LEN_HI: push_word = bits_ff[63:32];
         default:             push_word = '0;
      endcase
   end

   // One MD5 round
   always_comb begin
      case (cmd.round[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum  = f + a_ff + md5_pkg::ROUND_K[cmd.round] + blk_ff[md5_pkg::msg_index(cmd.round)];
      b_in = b_ff + md5_pkg::rotl32(sum, md5_pkg::rot_amount(cmd.round));
   end

   // Block buffer
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         blk_ff[pos_ff] <= push_word;
      end
   end

   // Working words: load from the chain on each write, advance on each round
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (cmd.round_en) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_in;
      end
   end

   // Chaining words, position and bit count
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         chain_ff[0] <= md5_pkg::INIT_A;
         chain_ff[1] <= md5_pkg::INIT_B;
         chain_ff[2] <= md5_pkg::INIT_C;
         chain_ff[3] <= md5_pkg::INIT_D;
         pos_ff      <= '0;
         bits_ff     <= '0;
      end else begin
         if (cmd.chain_add) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
         end
         if (cmd.push) begin
            pos_ff <= pos_ff + 4'd1;
            if (cmd.src == md5_pkg::SRC_DATA) begin
               bits_ff <= bits_ff + 64'(bit_add);
            end
         end
      end
   end

   // Hold the finished digest
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_ff <= chain_ff;
      end
   end

   // Deliver the digest one word at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (cmd.finish) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
         if (idx_ff == md5_pkg::LAST_DIGEST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = busy_ff;
   assign rsp_digest_word    = out_ff[idx_ff];
   assign rsp_word_number    = idx_ff;
   assign rsp_last_of_digest = (idx_ff == md5_pkg::LAST_DIGEST);

   assign status.pos       = pos_ff;
   assign status.emit_busy = busy_ff;

endmodule

FILE: sv/md5_message_digest_top.sv
// Channel  Direction  Word fields
// req      in         data_word[31:0], byte_count[2:0], last_word
// rsp      out        digest_word[31:0], word_number[1:0], last_of_digest
//
// A word that does not fill a block is simply written to the buffer; the word that fills one
// holds ready low through the 64 rounds of the single round unit and the
// chain add. The last word adds the padding words and one or two
// compressions, then the four digest words leave from an output register
// while the next message is already taken in. Reset is synchronous and
// restores the initial chaining words; a stalled rsp delays only the end of
// the next message.
module md5_message_digest_top (
   input logic      clock,
   input logic      reset,
   md5_req_if.sink  req_chan,
   md5_rsp_if.source rsp_chan
);

   md5_pkg::dp_cmd_type    cmd;
   md5_pkg::dp_status_type status;

   md5_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_last_word  (req_chan.last_word),
      .req_byte_count (req_chan.byte_count),
      .req_ready      (req_chan.ready),
      .status         (status),
      .cmd            (cmd)
   );

   md5_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_word      (req_chan.data_word),
      .req_byte_count     (req_chan.byte_count),
      .req_last_word      (req_chan.last_word),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_digest_word    (rsp_chan.digest_word),
      .rsp_word_number    (rsp_chan.word_number),
      .rsp_last_of_digest (rsp_chan.last_of_digest)
   );

endmodule

FILE: tb/sv/md5_message_digest_top_tb.sv
`timescale 1ns / 1ps

module md5_message_digest_top_tb;

   localparam int DIRECTED_N   = 22;
   localparam int RANDOM_WORDS = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int REPORT_MAX   = 10;

   // Digests of the empty message and of "abc", word A in the low slot
   localparam logic [3:0][31:0] EMPTY_DIGEST =
      {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
   localparam logic [3:0][31:0] ABC_DIGEST =
      {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};

   // Left rotate amounts, indexed by {round phase, round[1:0]}
   localparam int unsigned SHIFT_TAB [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   typedef struct packed {
      logic [31:0]      data;
      logic [2:0]       cnt;
      logic             last;
      logic             known;
      logic [3:0][31:0] digest;
   } msg_word_type;

   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  num;
      logic        last;
   } digest_word_type;

   logic clock;
   logic reset;

   md5_req_if req_if ();
   md5_rsp_if rsp_if ();

   md5_message_digest_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Directed words: known answers, byte count extremes, a two-block tail
   msg_word_type directed_rows [DIRECTED_N] = '{
      '{32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{32'hffffffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{32'hff636261, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
      '{32'hffffffff, 3'd1, 1'b1, 1'b0, '0},
      '{32'h0000ffff, 3'd2, 1'b1, 1'b0, '0},
      '{32'hffffffff, 3'd4, 1'b1, 1'b0, '0},
      '{32'h64636261, 3'd5, 1'b1, 1'b0, '0},
      '{32'h64636261, 3'd7, 1'b1, 1'b0, '0},
      '{32'h00000000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hffffffff, 3'd7, 1'b0, 1'b0, '0},
      '{32'h80000000, 3'd1, 1'b0, 1'b0, '0},
      '{32'h00000001, 3'd2, 1'b0, 1'b0, '0},
      '{32'ha5a5a5a5, 3'd3, 1'b0, 1'b0, '0},
      '{32'h5a5a5a5a, 3'd4, 1'b0, 1'b0, '0},
      '{32'h01234567, 3'd5, 1'b0, 1'b0, '0},
      '{32'h89abcdef, 3'd6, 1'b0, 1'b0, '0},
      '{32'hfedcba98, 3'd0, 1'b0, 1'b0, '0},
      '{32'h76543210, 3'd7, 1'b0, 1'b0, '0},
      '{32'h0000ffff, 3'd1, 1'b0, 1'b0, '0},
      '{32'hffff0000, 3'd2, 1'b0, 1'b0, '0},
      '{32'hdeadbeef, 3'd3, 1'b0, 1'b0, '0},
      '{32'h12345678, 3'd4, 1'b1, 1'b0, '0}
   };

   msg_word_type    message_q [$];
   digest_word_type pending_digest_q [$];

   // Digest state of the predictor
   logic [31:0] chain [4];
   logic [31:0] blk [16];
   logic [3:0]  blk_pos;
   logic [63:0] msg_bits;

   int cycle_count;
   int err_count;
   int words_sent;
   int messages_sent;
   int digests_checked;
   int msg_len;
   int longest_msg;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic void clear_digest_state();
      chain[0] = md5_pkg::INIT_A;
      chain[1] = md5_pkg::INIT_B;
      chain[2] = md5_pkg::INIT_C;
      chain[3] = md5_pkg::INIT_D;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      blk_pos  = '0;
      msg_bits = '0;
   endfunction

   // Run the 64 rounds over the block buffer and fold into the chain
   function automatic void compress_block();
      logic [31:0] a, b, c, d, f, t;
      logic [3:0]  k;
      logic [1:0]  phase;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
         phase = 2'(r >> 4);
         case (phase)
            2'd0: begin
               f = (b & c) | (~b & d);
               k = 4'(r);
            end
            2'd1: begin
               f = (d & b) | (~d & c);
               k = 4'(5 * r + 1);
            end
            2'd2: begin
               f = b ^ c ^ d;
               k = 4'(3 * r + 5);
            end
            default: begin
               f = c ^ (b | ~d);
               k = 4'(7 * r);
            end
         endcase
         t = f + a + md5_pkg::ROUND_K[r] + blk[k];
         a = d;
         d = c;
         c = b;
         b = b + rotl(t, SHIFT_TAB[{phase, 2'(r)}]);
      end
      chain[0] = chain[0] + a;
      chain[1] = chain[1] + b;
      chain[2] = chain[2] + c;
      chain[3] = chain[3] + d;
   endfunction

   function automatic void push_block_word(input logic [31:0] w);
      blk[blk_pos] = w;
      blk_pos = blk_pos + 4'd1;
      if (blk_pos == 4'd0) compress_block();
   endfunction

   // Take one message word; on the last one pad, finish and hand back the digest
   function automatic bit absorb_word(input logic [31:0] data, input logic [2:0] cnt,
                                      input logic last, output logic [3:0][31:0] digest);
      logic [2:0]  n;
      logic [31:0] keep;
      digest = '0;
      if (!last) begin
         msg_bits = msg_bits + 64'd32;
         push_block_word(data);
         return 1'b0;
      end
      n = (cnt > 3'd4) ? 3'd4 : cnt;
      msg_bits = msg_bits + {58'd0, n, 3'b000};
      if (n == 3'd4) begin
         push_block_word(data);
         push_block_word(32'h80);
      end else begin
         keep = ~(32'hffffffff << {n, 3'b000});
         push_block_word((data & keep) | (32'h80 << {n, 3'b000}));
      end
      while (blk_pos != 4'd14) push_block_word(32'h0);
      push_block_word(msg_bits[31:0]);
      push_block_word(msg_bits[63:32]);
      for (int i = 0; i < 4; i++) digest[i] = chain[i];
      clear_digest_state();
      return 1'b1;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle count and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d digest words outstanding",
                  cycle_count, pending_digest_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: ready rotates through four stall patterns in turn
   always @(negedge clock) begin
      case ((cycle_count / 97) % 4)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_if.ready <= cycle_count[3];
      endcase
   end

   // Check each digest word against the oldest expectation
   always @(posedge clock) begin
      digest_word_type exp_w;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_digest_q.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_MAX)
               $display("Unexpected digest word %h num %0d last %0b",
                        rsp_if.digest_word, rsp_if.word_number, rsp_if.last_of_digest);
         end else begin
            exp_w = pending_digest_q.pop_front();
            digests_checked++;
            if (rsp_if.digest_word !== exp_w.data || rsp_if.word_number !== exp_w.num ||
                rsp_if.last_of_digest !== exp_w.last) begin
               err_count++;
               if (err_count <= REPORT_MAX)
                  $display("Digest mismatch: expected %h num %0d last %0b, got %h num %0d last %0b",
                           exp_w.data, exp_w.num, exp_w.last, rsp_if.digest_word,
                           rsp_if.word_number, rsp_if.last_of_digest);
            end
         end
      end
   end

   // Stimulus, sender and end of run
   initial begin
      msg_word_type     w;
      logic [3:0][31:0] calc;
      digest_word_type  exp_w;
      int               len;
      int               burst_left;
      int               gap;
      cycle_count        = 0;
      err_count          = 0;
      words_sent         = 0;
      messages_sent      = 0;
      digests_checked    = 0;
      msg_len            = 0;
      longest_msg        = 0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_word   = '0;
      req_if.byte_count  = '0;
      req_if.last_word   = 1'b0;
      rsp_if.ready       = 1'b0;
      clear_digest_state();

      // Directed table first, then random messages of mostly short length
      for (int i = 0; i < DIRECTED_N; i++) message_q.push_back(directed_rows[i]);
      while (message_q.size() < DIRECTED_N + RANDOM_WORDS) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
         for (int j = 0; j <= len; j++) begin
            w       = '0;
            w.data  = $urandom;
            w.cnt   = 3'($urandom_range(0, 7));
            w.last  = (j == len);
            message_q.push_back(w);
         end
      end

      // Hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Send words in bursts with random gaps
      burst_left = 0;
      foreach (message_q[i]) begin
         w = message_q[i];
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_if.valid      <= 1'b1;
         req_if.data_word  <= w.data;
         req_if.byte_count <= w.cnt;
         req_if.last_word  <= w.last;
         @(posedge clock);
         while (req_if.ready !== 1'b1) @(posedge clock);

         // Word accepted: advance the predictor
         words_sent++;
         msg_len++;
         if (absorb_word(w.data, w.cnt, w.last, calc)) begin
            if (w.known) calc = w.digest;
            for (int k = 0; k < 4; k++) begin
               exp_w.data = calc[k];
               exp_w.num  = 2'(k);
               exp_w.last = (k == 3);
               pending_digest_q.push_back(exp_w);
            end
            messages_sent++;
            if (msg_len > longest_msg) longest_msg = msg_len;
            msg_len = 0;
         end
         burst_left--;
         @(negedge clock);
      end
      req_if.valid <= 1'b0;

      // Drain outstanding digests, then watch for stray words
      while (pending_digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message words in %0d messages (longest %0d words)",
               words_sent, messages_sent, longest_msg);
      $display("Checked %0d digest words, %0d mismatches", digests_checked, err_count);
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
